### rtl/half_duplex_uart_assert.svh
`ifndef HALF_DUPLEX_UART_ASSERT_SVH
`define HALF_DUPLEX_UART_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HDU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("half_duplex_uart: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HDU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("half_duplex_uart: check failed");

`endif

### rtl/hdu_pkg.sv
package hdu_pkg;

  localparam int DATA_BITS_DEF = 8;
  localparam int ADDR_W        = 3;
  localparam int PDATA_W       = 32;

  localparam logic [7:0] BIT_TIME_RST = 8'd104;
  localparam logic [4:0] EDGE_LAT_RST = 5'd0;

  // Register index, taken from paddr[2]
  localparam logic REG_BIT_TIME = 1'b0;
  localparam logic REG_EDGE_LAT = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  typedef struct packed {
    logic       rx_level;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_ack;
  } in_t;

  typedef struct packed {
    logic       tx_level;
    logic       send_accepted;
    logic       busy_res;
    logic       rx_ready;
    logic [7:0] rx_byte;
  } out_t;

  typedef struct packed {
    logic [7:0] bit_time;
    logic [4:0] edge_latency;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] tick_count;
    logic [7:0] compare_value;
    logic [3:0] bits_left;
    logic [7:0] rx_held;
    logic       rx_full;
    logic       prev_rx_level;
    logic       tx_line;
  } ctl_t;

endpackage

### rtl/hdu_cfg.sv
module hdu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdu_pkg::ADDR_W-1:0]  paddr,
  input  logic [hdu_pkg::PDATA_W-1:0] pwdata,
  output logic [hdu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hdu_pkg::cfg_t               cfg
);
  import hdu_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_BIT_TIME: cfg_nxt.bit_time     = pwdata[7:0];
        REG_EDGE_LAT: cfg_nxt.edge_latency = pwdata[4:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_time     <= BIT_TIME_RST;
      cfg_r.edge_latency <= EDGE_LAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BIT_TIME: prdata = PDATA_W'(cfg_r.bit_time);
      REG_EDGE_LAT: prdata = PDATA_W'(cfg_r.edge_latency);
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/hdu_step.sv
module hdu_step #(
  parameter int DATA_BITS = hdu_pkg::DATA_BITS_DEF
) (
  input  hdu_pkg::cfg_t          cfg,
  input  hdu_pkg::in_t           in_item,
  input  hdu_pkg::ctl_t          ctl,
  input  logic [DATA_BITS-1:0]   rx_shift,
  input  logic [DATA_BITS+1:0]   tx_shift,
  output hdu_pkg::ctl_t          ctl_nxt,
  output logic [DATA_BITS-1:0]   rx_shift_nxt,
  output logic [DATA_BITS+1:0]   tx_shift_nxt,
  output hdu_pkg::out_t          result
);
  import hdu_pkg::*;

  logic [8:0] delay3;
  logic [7:0] delay_sat;
  logic [7:0] first_delay;
  logic       tick_evt;
  logic       accepted;

  // First sample lands mid data bit 0: (bit_time/2)*3, saturated, minus edge lag
  always_comb begin
    delay3      = {2'b00, cfg.bit_time[7:1]} + {1'b0, cfg.bit_time[7:1], 1'b0};
    delay_sat   = (delay3 > 9'd255) ? 8'hFF : delay3[7:0];
    first_delay = ({3'b000, cfg.edge_latency} > delay_sat) ? 8'd0
                : delay_sat - {3'b000, cfg.edge_latency};
  end

  assign tick_evt = (ctl.tick_count >= ctl.compare_value);

  always_comb begin
    ctl_nxt      = ctl;
    rx_shift_nxt = rx_shift;
    tx_shift_nxt = tx_shift;
    accepted     = 1'b0;

    if (in_item.read_ack) begin
      ctl_nxt.rx_full = 1'b0;
    end

    case (ctl.mode)
      MODE_RX: begin
        ctl_nxt.tick_count = tick_evt ? 8'd0 : ctl.tick_count + 8'd1;
        if (tick_evt) begin
          ctl_nxt.compare_value = cfg.bit_time;
          if (ctl.bits_left != 4'd0) begin
            rx_shift_nxt      = {in_item.rx_level, rx_shift[DATA_BITS-1:1]};
            ctl_nxt.bits_left = ctl.bits_left - 4'd1;
          end else begin
            // stop slot: store the byte, overwrite any unread one
            ctl_nxt.rx_held = 8'(rx_shift);
            ctl_nxt.rx_full = 1'b1;
            ctl_nxt.mode    = MODE_IDLE;
          end
        end
      end
      MODE_TX: begin
        ctl_nxt.tick_count = tick_evt ? 8'd0 : ctl.tick_count + 8'd1;
        if (tick_evt) begin
          ctl_nxt.compare_value = cfg.bit_time;
          ctl_nxt.tx_line       = tx_shift[0];
          tx_shift_nxt          = {1'b0, tx_shift[DATA_BITS+1:1]};
          if (ctl.bits_left <= 4'd1) begin
            ctl_nxt.bits_left = 4'd0;
            ctl_nxt.mode      = MODE_IDLE;
          end else begin
            ctl_nxt.bits_left = ctl.bits_left - 4'd1;
          end
        end
      end
      default: begin
        ctl_nxt.mode = MODE_IDLE;
        if (in_item.rx_level != ctl.prev_rx_level) begin
          ctl_nxt.compare_value = first_delay;
          ctl_nxt.tick_count    = 8'd0;
          ctl_nxt.bits_left     = 4'(DATA_BITS);
          ctl_nxt.mode          = MODE_RX;
        end else if (in_item.send_valid) begin
          // stop, data, start from MSB down to LSB
          tx_shift_nxt          = {1'b1, in_item.send_byte[DATA_BITS-1:0], 1'b0};
          ctl_nxt.bits_left     = 4'(DATA_BITS + 2);
          ctl_nxt.compare_value = cfg.bit_time;
          ctl_nxt.tick_count    = 8'd0;
          ctl_nxt.mode          = MODE_TX;
          accepted              = 1'b1;
        end
      end
    endcase

    ctl_nxt.prev_rx_level = in_item.rx_level;
  end

  always_comb begin
    result.tx_level      = ctl_nxt.tx_line;
    result.send_accepted = accepted;
    result.busy_res      = (ctl_nxt.mode != MODE_IDLE);
    result.rx_ready      = ctl_nxt.rx_full;
    result.rx_byte       = ctl_nxt.rx_held;
  end

endmodule

### rtl/half_duplex_uart.sv
// Half-duplex 8N1 serial port stepped by prescaled timer ticks.
// Input channel (in_valid/in_ready/in_data): one transaction per tick, carrying
// the sampled receive level, an optional byte to send and a read acknowledge.
// Result channel (out_valid/out_ready/out_data): exactly one transaction per
// input tick, with transmit level, send acceptance, busy, rx_ready and the last
// received byte, all as they stand after that tick.
// The result is registered: a tick's result shows in the cycle after it is taken.
// Throughput is one tick per cycle; the single result register decides it,
// and in_ready stays high while that register is empty or being drained.
// When the receiver stalls (out_ready low with a result held), in_ready drops
// and the port state holds until the result is taken.
// The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// bit_time at address 0 and edge_latency at address 4; pready is always high.
// Write registers only while no tick is in flight.
// Reset (rst_n low, synchronous) returns to idle with the transmit line high,
// no byte held, bit_time 104 and edge_latency 0; no result is pending.
module half_duplex_uart #(
  parameter int DATA_BITS = hdu_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hdu_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hdu_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdu_pkg::ADDR_W-1:0]  paddr,
  input  logic [hdu_pkg::PDATA_W-1:0] pwdata,
  output logic [hdu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import hdu_pkg::*;

  `include "half_duplex_uart_assert.svh"

  cfg_t                 cfg;
  ctl_t                 ctl_r;
  ctl_t                 ctl_nxt;
  logic [DATA_BITS-1:0] rx_shift_r;
  logic [DATA_BITS-1:0] rx_shift_nxt;
  logic [DATA_BITS+1:0] tx_shift_r;
  logic [DATA_BITS+1:0] tx_shift_nxt;
  out_t                 result;
  out_t                 out_data_r;
  logic                 out_valid_r;
  logic                 in_fire;

  hdu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hdu_step #(
    .DATA_BITS (DATA_BITS)
  ) u_step (
    .cfg          (cfg),
    .in_item      (in_data),
    .ctl          (ctl_r),
    .rx_shift     (rx_shift_r),
    .tx_shift     (tx_shift_r),
    .ctl_nxt      (ctl_nxt),
    .rx_shift_nxt (rx_shift_nxt),
    .tx_shift_nxt (tx_shift_nxt),
    .result       (result)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode          <= MODE_IDLE;
      ctl_r.tick_count    <= 8'd0;
      ctl_r.compare_value <= BIT_TIME_RST;
      ctl_r.bits_left     <= 4'd0;
      ctl_r.rx_held       <= 8'd0;
      ctl_r.rx_full       <= 1'b0;
      ctl_r.prev_rx_level <= 1'b1;
      ctl_r.tx_line       <= 1'b1;
      rx_shift_r          <= '0;
      tx_shift_r          <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        ctl_r      <= ctl_nxt;
        rx_shift_r <= rx_shift_nxt;
        tx_shift_r <= tx_shift_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on each accepted tick, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HDU_ASSERT_NXT(a_send_only_idle, in_fire && (ctl_r.mode != MODE_IDLE),
    !out_data_r.send_accepted)
  `HDU_ASSERT_IMP(a_accept_busy, out_valid_r && out_data_r.send_accepted,
    out_data_r.busy_res)
  `HDU_ASSERT_IMP(a_full_from_rx, $rose(ctl_r.rx_full),
    $past(ctl_r.mode) == MODE_RX)
  `HDU_ASSERT_IMP(a_bits_bound, 1'b1, ctl_r.bits_left <= 4'(DATA_BITS + 2))
  `HDU_ASSERT_NXT(a_stall_holds, !in_ready, $stable(ctl_r))

endmodule
